FILE: hw/rtl/random_probe_refcount_node_store_defines.svh
// Assertion macros shared by the node store RTL.
`ifndef RANDOM_PROBE_REFCOUNT_NODE_STORE_DEFINES_SVH
`define RANDOM_PROBE_REFCOUNT_NODE_STORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RPRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RPRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rprc_pkg.sv
// Types and constants shared by the node store RTL.
package rprc_pkg;

    localparam int DATA_W      = 32;
    localparam int OPC_W       = 3;
    localparam int SLOT_W      = 10;
    localparam int PROBE_W     = 10;
    localparam int ENTRIES_DEF = 1024;
    localparam int PADDR_W     = 4;

    localparam logic [PROBE_W-1:0] MAX_PROBES_RST = 10'd1000;
    localparam logic [DATA_W-1:0]  SEED_RST       = 32'd1;
    localparam logic [DATA_W-1:0]  ALL_ONES       = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC   = 3'd0,
        OP_TAKE    = 3'd1,
        OP_DROP    = 3'd2,
        OP_RD_DATA = 3'd3,
        OP_RD_NEXT = 3'd4,
        OP_WR_NEXT = 3'd5,
        OP_WR_DATA = 3'd6,
        OP_REINIT  = 3'd7
    } t_opcode;

    typedef enum logic [1:0] {
        REG_MAX_PROBES     = 2'd0,
        REG_CLEAR_ON_ALLOC = 2'd1,
        REG_RANDOM_SEED    = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        ALU_XORSHIFT = 2'd0,
        ALU_SCALE    = 2'd1,
        ALU_INC      = 2'd2,
        ALU_DEC      = 2'd3
    } t_alu_op;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_DRAW,
        ST_MAP,
        ST_READ,
        ST_CHECK,
        ST_FETCH,
        ST_EXEC,
        ST_REINIT,
        ST_RESP
    } t_state;

endpackage

FILE: hw/rtl/rprc_in_if.sv
// Request channel of the node store: opcode, slot and value.
interface rprc_in_if;
    logic                           valid;
    logic                           ready;
    logic [rprc_pkg::OPC_W-1:0]     opcode;
    logic [rprc_pkg::SLOT_W-1:0]    slot;
    logic [rprc_pkg::DATA_W-1:0]    value;

    modport source (output valid, output opcode, output slot, output value, input ready);
    modport sink   (input valid, input opcode, input slot, input value, output ready);
endinterface

FILE: hw/rtl/rprc_out_if.sv
// Response channel of the node store: result, ok and probe count.
interface rprc_out_if;
    logic                           valid;
    logic                           ready;
    logic [rprc_pkg::DATA_W-1:0]    result;
    logic                           ok;
    logic [rprc_pkg::PROBE_W-1:0]   probes;

    modport source (output valid, output result, output ok, output probes, input ready);
    modport sink   (input valid, input result, input ok, input probes, output ready);
endinterface

FILE: hw/rtl/random_probe_refcount_node_store.sv
// Top level of the reference-counted node store with random-probe allocation.
//
// The store holds ENTRIES slots, each with a 32-bit reference-count tag, a data
// word and a next link, kept in three single-port-write RAMs with registered
// reads. One item is handled at a time by a small sequencer that drives a single
// shared arithmetic unit. Take ref, drop ref, reads and writes of a slot pass
// from acceptance to the result register through fetch, execute and respond,
// and a slot out of range goes straight to respond. An allocation repeats its
// probe until it finds a free slot or runs out of probes; each probe steps the
// xorshift32 generator, scales the draw onto a slot index, reads the tag and
// tests it in turn through the one unit and the one RAM read port. The default
// limit is 1000 probes. Reinit rewrites every tag and data word, one slot per
// cycle. After reset the block runs a clearing pass over all ENTRIES slots, with
// the request channel not ready, before it accepts its first item; configuration
// writes are taken during the pass. The result register lets the next item be
// accepted while a result still waits.
// Configuration registers sit on an APB-style port: max_probes at 0x0,
// clear_on_alloc at 0x4 and random_seed at 0x8; writing the seed reloads the
// generator at once.

`include "random_probe_refcount_node_store_defines.svh"

module random_probe_refcount_node_store #(
    parameter int ENTRIES = rprc_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rprc_in_if.sink                       i_in,
    rprc_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rprc_pkg::PADDR_W-1:0]  paddr,
    input  logic [rprc_pkg::DATA_W-1:0]   pwdata,
    output logic [rprc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    localparam int DW    = rprc_pkg::DATA_W;
    localparam int PW    = rprc_pkg::PROBE_W;
    localparam int SW    = rprc_pkg::SLOT_W;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // Sequencer registers.
    rprc_pkg::t_state  r_state,  n_state;
    rprc_pkg::t_opcode r_op,     n_op;
    logic [SW-1:0]     r_slot,   n_slot;
    logic [DW-1:0]     r_value,  n_value;
    logic [PW-1:0]     r_probes, n_probes;
    logic [DW-1:0]     r_rng,    n_rng;
    logic [IDX_W-1:0]  r_idx,    n_idx;
    logic [IDX_W-1:0]  r_clr_idx, n_clr_idx;
    logic [DW-1:0]     r_res_result, n_res_result;
    logic              r_res_ok,     n_res_ok;
    logic [PW-1:0]     r_res_probes, n_res_probes;

    // Result register.
    logic              r_out_valid;
    logic [DW-1:0]     r_out_result;
    logic              r_out_ok;
    logic [PW-1:0]     r_out_probes;
    logic              out_load;

    // Configuration registers.
    logic [PW-1:0]     r_max_probes;
    logic              r_clear_on_alloc;
    logic [DW-1:0]     r_seed;
    logic              cfg_write;
    logic              seed_write;

    // RAM and arithmetic unit connections.
    logic [IDX_W-1:0]  ram_raddr;
    logic [IDX_W-1:0]  ram_waddr;
    logic              tag_we,  data_we,  next_we;
    logic [DW-1:0]     tag_wdata, data_wdata, next_wdata;
    logic [DW-1:0]     tag_rd,  data_rd,  next_rd;
    rprc_pkg::t_alu_op alu_op;
    logic [DW-1:0]     alu_a;
    logic [DW-1:0]     alu_y;

    logic [DW-1:0]     slot_ext;
    logic [IDX_W-1:0]  slot_addr;
    logic              in_range;

    assign slot_ext  = DW'(r_slot);
    assign slot_addr = slot_ext[IDX_W-1:0];
    // Range test on the incoming slot, done at acceptance.
    assign in_range  = DW'(i_in.slot) < DW'(ENTRIES);

    rprc_alu #(
        .ENTRIES (ENTRIES)
    ) u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .o_y  (alu_y)
    );

    rprc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (ram_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (tag_rd)
    );

    rprc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (ram_waddr),
        .i_wdata (data_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (data_rd)
    );

    rprc_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (next_we),
        .i_waddr (ram_waddr),
        .i_wdata (next_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (next_rd)
    );

    // State register and sequencer data registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rprc_pkg::ST_INIT;
            r_clr_idx <= '0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
        end
        r_op         <= n_op;
        r_slot       <= n_slot;
        r_value      <= n_value;
        r_probes     <= n_probes;
        r_idx        <= n_idx;
        r_res_result <= n_res_result;
        r_res_ok     <= n_res_ok;
        r_res_probes <= n_res_probes;
    end

    // Next state, RAM control and arithmetic unit selection.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_slot       = r_slot;
        n_value      = r_value;
        n_probes     = r_probes;
        n_rng        = r_rng;
        n_idx        = r_idx;
        n_clr_idx    = r_clr_idx;
        n_res_result = r_res_result;
        n_res_ok     = r_res_ok;
        n_res_probes = r_res_probes;
        i_in.ready   = 1'b0;
        out_load     = 1'b0;
        ram_raddr    = r_idx;
        ram_waddr    = r_idx;
        tag_we       = 1'b0;
        data_we      = 1'b0;
        next_we      = 1'b0;
        tag_wdata    = '0;
        data_wdata   = rprc_pkg::ALL_ONES;
        next_wdata   = rprc_pkg::ALL_ONES;
        alu_op       = rprc_pkg::ALU_XORSHIFT;
        alu_a        = r_rng;

        unique case (r_state)
            rprc_pkg::ST_INIT, rprc_pkg::ST_REINIT: begin
                // Sweep: tags free, data words back to their index. Next links
                // are only reset by the pass after reset.
                ram_waddr  = r_clr_idx;
                tag_we     = 1'b1;
                data_we    = 1'b1;
                data_wdata = DW'(r_clr_idx);
                next_we    = (r_state == rprc_pkg::ST_INIT);
                n_clr_idx  = r_clr_idx + IDX_W'(1);
                if (r_clr_idx == LAST_IDX) begin
                    n_clr_idx = '0;
                    if (r_state == rprc_pkg::ST_INIT) begin
                        n_state = rprc_pkg::ST_IDLE;
                    end else begin
                        n_res_result = '0;
                        n_res_ok     = 1'b1;
                        n_res_probes = '0;
                        n_state      = rprc_pkg::ST_RESP;
                    end
                end
            end

            rprc_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_op         = rprc_pkg::t_opcode'(i_in.opcode);
                    n_slot       = i_in.slot;
                    n_value      = i_in.value;
                    n_probes     = '0;
                    n_clr_idx    = '0;
                    n_res_result = rprc_pkg::ALL_ONES;
                    n_res_ok     = 1'b0;
                    n_res_probes = '0;
                    unique case (rprc_pkg::t_opcode'(i_in.opcode))
                        rprc_pkg::OP_ALLOC:  n_state = rprc_pkg::ST_DRAW;
                        rprc_pkg::OP_REINIT: n_state = rprc_pkg::ST_REINIT;
                        default: begin
                            n_state = in_range ? rprc_pkg::ST_FETCH : rprc_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            rprc_pkg::ST_DRAW: begin
                if (r_probes < r_max_probes) begin
                    alu_op   = rprc_pkg::ALU_XORSHIFT;
                    alu_a    = r_rng;
                    n_rng    = alu_y;
                    n_probes = r_probes + PW'(1);
                    n_state  = rprc_pkg::ST_MAP;
                end else begin
                    // Probe limit reached without a free slot.
                    n_res_result = rprc_pkg::ALL_ONES;
                    n_res_ok     = 1'b0;
                    n_res_probes = r_probes;
                    n_state      = rprc_pkg::ST_RESP;
                end
            end

            rprc_pkg::ST_MAP: begin
                alu_op  = rprc_pkg::ALU_SCALE;
                alu_a   = r_rng;
                n_idx   = alu_y[IDX_W-1:0];
                n_state = rprc_pkg::ST_READ;
            end

            rprc_pkg::ST_READ: begin
                ram_raddr = r_idx;
                n_state   = rprc_pkg::ST_CHECK;
            end

            rprc_pkg::ST_CHECK: begin
                if (tag_rd == '0) begin
                    ram_waddr    = r_idx;
                    tag_we       = 1'b1;
                    tag_wdata    = DW'(1);
                    data_we      = r_clear_on_alloc;
                    next_we      = r_clear_on_alloc;
                    n_res_result = DW'(r_idx);
                    n_res_ok     = 1'b1;
                    n_res_probes = r_probes;
                    n_state      = rprc_pkg::ST_RESP;
                end else begin
                    n_state = rprc_pkg::ST_DRAW;
                end
            end

            rprc_pkg::ST_FETCH: begin
                ram_raddr = slot_addr;
                n_state   = rprc_pkg::ST_EXEC;
            end

            rprc_pkg::ST_EXEC: begin
                ram_waddr    = slot_addr;
                alu_a        = tag_rd;
                n_res_probes = '0;
                n_state      = rprc_pkg::ST_RESP;
                unique case (r_op)
                    rprc_pkg::OP_TAKE: begin
                        alu_op = rprc_pkg::ALU_INC;
                        if (tag_rd != '0) begin
                            tag_we       = 1'b1;
                            tag_wdata    = alu_y;
                            n_res_result = alu_y;
                            n_res_ok     = 1'b1;
                        end
                    end
                    rprc_pkg::OP_DROP: begin
                        alu_op = rprc_pkg::ALU_DEC;
                        if (tag_rd != '0) begin
                            tag_we       = 1'b1;
                            tag_wdata    = alu_y;
                            n_res_result = tag_rd;
                            n_res_ok     = 1'b1;
                        end
                    end
                    rprc_pkg::OP_RD_DATA: begin
                        n_res_result = data_rd;
                        n_res_ok     = 1'b1;
                    end
                    rprc_pkg::OP_RD_NEXT: begin
                        n_res_result = next_rd;
                        n_res_ok     = 1'b1;
                    end
                    rprc_pkg::OP_WR_NEXT: begin
                        next_we      = 1'b1;
                        next_wdata   = r_value;
                        n_res_result = '0;
                        n_res_ok     = 1'b1;
                    end
                    rprc_pkg::OP_WR_DATA: begin
                        data_we      = 1'b1;
                        data_wdata   = r_value;
                        n_res_result = '0;
                        n_res_ok     = 1'b1;
                    end
                    default: begin
                        n_res_result = rprc_pkg::ALL_ONES;
                        n_res_ok     = 1'b0;
                    end
                endcase
            end

            rprc_pkg::ST_RESP: begin
                if (!r_out_valid || o_out.ready) begin
                    out_load = 1'b1;
                    n_state  = rprc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = rprc_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register: holds an item until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (out_load) begin
            r_out_result <= r_res_result;
            r_out_ok     <= r_res_ok;
            r_out_probes <= r_res_probes;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.result = r_out_result;
    assign o_out.ok     = r_out_ok;
    assign o_out.probes = r_out_probes;

    // Configuration port. A seed write reloads the generator directly.
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign seed_write = cfg_write &&
                        (rprc_pkg::t_reg_idx'(paddr[3:2]) == rprc_pkg::REG_RANDOM_SEED);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_probes     <= rprc_pkg::MAX_PROBES_RST;
            r_clear_on_alloc <= 1'b1;
            r_seed           <= rprc_pkg::SEED_RST;
            r_rng            <= rprc_pkg::SEED_RST;
        end else begin
            if (seed_write) begin
                r_rng <= pwdata;
            end else begin
                r_rng <= n_rng;
            end
            if (cfg_write) begin
                unique case (rprc_pkg::t_reg_idx'(paddr[3:2]))
                    rprc_pkg::REG_MAX_PROBES:     r_max_probes     <= pwdata[PW-1:0];
                    rprc_pkg::REG_CLEAR_ON_ALLOC: r_clear_on_alloc <= pwdata[0];
                    rprc_pkg::REG_RANDOM_SEED:    r_seed           <= pwdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        unique case (rprc_pkg::t_reg_idx'(paddr[3:2]))
            rprc_pkg::REG_MAX_PROBES:     prdata = DW'(r_max_probes);
            rprc_pkg::REG_CLEAR_ON_ALLOC: prdata = DW'(r_clear_on_alloc);
            rprc_pkg::REG_RANDOM_SEED:    prdata = r_seed;
            default:                      prdata = '0;
        endcase
    end

    // The sequencer never takes two items in consecutive cycles.
    `RPRC_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "item accepted while busy")
    // A probe under way has been counted and stays within the limit.
    `RPRC_ASSERT_IMP(a_probe_bound, i_clk, i_rst_n, r_state == rprc_pkg::ST_MAP, r_probes != '0 && r_probes <= r_max_probes, "probe count out of bounds")
    // A result only appears after the sequencer reached its respond state.
    `RPRC_ASSERT_IMP(a_out_from_resp, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == rprc_pkg::ST_RESP, "result without respond state")
    // The store is only written by states that own a write.
    `RPRC_ASSERT_IMP(a_write_states, i_clk, i_rst_n, tag_we || data_we || next_we, r_state == rprc_pkg::ST_CHECK || r_state == rprc_pkg::ST_EXEC || r_state == rprc_pkg::ST_INIT || r_state == rprc_pkg::ST_REINIT, "store written in wrong state")
    // Finding a free slot ends the allocation with success.
    `RPRC_ASSERT_NXT(a_alloc_success, i_clk, i_rst_n, r_state == rprc_pkg::ST_CHECK && tag_rd == '0, r_state == rprc_pkg::ST_RESP && r_res_ok, "free slot not allocated")

endmodule

FILE: hw/rtl/rprc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rprc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/rprc_alu.sv
// Shared arithmetic unit: generator step, slot scaling and tag increment/decrement.
module rprc_alu #(
    parameter int ENTRIES = rprc_pkg::ENTRIES_DEF
) (
    input  rprc_pkg::t_alu_op              i_op,
    input  logic [rprc_pkg::DATA_W-1:0]    i_a,
    output logic [rprc_pkg::DATA_W-1:0]    o_y
);
    localparam int DW     = rprc_pkg::DATA_W;
    localparam int ENT_W  = $clog2(ENTRIES + 1);
    localparam int PROD_W = DW + ENT_W;

    logic [DW-1:0]     s1;
    logic [DW-1:0]     s2;
    logic [DW-1:0]     s3;
    logic [PROD_W-1:0] prod;

    always_comb begin
        // One xorshift32 step.
        s1 = i_a ^ (i_a << 13);
        s2 = s1 ^ (s1 >> 17);
        s3 = s2 ^ (s2 << 5);
        // Upper word of the product maps the draw onto the slot range.
        prod = PROD_W'(i_a) * PROD_W'(ENTRIES);
        unique case (i_op)
            rprc_pkg::ALU_XORSHIFT: o_y = s3;
            rprc_pkg::ALU_SCALE:    o_y = DW'(prod >> DW);
            rprc_pkg::ALU_INC:      o_y = i_a + DW'(1);
            rprc_pkg::ALU_DEC:      o_y = i_a - DW'(1);
            default:                o_y = i_a;
        endcase
    end
endmodule
